// ===== hdl/msws_pkg.sv =====
// Shared constants, codes and controller/datapath types for the window statistics core.
// No dependencies; every other file refers to this package by scoped names.
package msws_pkg;

	localparam int MAX_PASSES = 16;
	localparam int WINDOW     = 64;

	localparam int PASS_W = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
	localparam int POS_W  = $clog2(MAX_PASSES + 1);
	localparam int WIN_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int DEPTH  = MAX_PASSES * WINDOW;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W  = 32 + FILL_W;
	localparam int DCNT_W = $clog2(SUM_W + 1);

	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		CMD_ENTRY   = 2'd0,
		CMD_EMPTY   = 2'd1,
		CMD_SUMMARY = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CODE_SAME     = 2'd0,
		CODE_CHANGED  = 2'd1,
		CODE_REJECTED = 2'd2,
		CODE_TRUNC    = 2'd3
	} code_t;

	typedef enum logic [1:0] {
		FST_REJECTED = 2'd0,
		FST_SAME     = 2'd1,
		FST_CHANGED  = 2'd2,
		FST_TRUNC    = 2'd3
	} fstat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_STEP,
		S_CLOSE,
		S_EMIT_STATUS,
		S_SUM_SEL,
		S_SUM_RD,
		S_SUM_ACC,
		S_DIV_INIT,
		S_DIV,
		S_EMIT_SUM
	} state_t;

	typedef struct packed {
		logic latch_in;
		logic do_step;
		logic do_close;
		logic load_status;
		logic sum_init;
		logic sum_next;
		logic sum_begin;
		logic acc;
		logic div_begin;
		logic div_step;
		logic load_sum;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic fend;
		logic sel_end;
		logic fill_zero;
		logic acc_last;
		logic div_done;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hdl/msws_ctrl.sv =====
// Sequencing state machine of the window statistics core.
// Depends on msws_pkg; drives msws_dpath through command/status structs.
module msws_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  msws_pkg::dp_sts_t sts,
	output msws_pkg::ctl_cmd_t cmd
);

	msws_pkg::state_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= msws_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			msws_pkg::S_IDLE: begin
				if (in_valid) begin
					case (sts.cmd)
						msws_pkg::CMD_ENTRY, msws_pkg::CMD_EMPTY: state_d = msws_pkg::S_STEP;
						msws_pkg::CMD_SUMMARY:                    state_d = msws_pkg::S_SUM_SEL;
						default:                                  state_d = msws_pkg::S_IDLE;
					endcase
				end
			end
			msws_pkg::S_STEP: begin
				if (sts.cmd == msws_pkg::CMD_EMPTY || sts.fend) state_d = msws_pkg::S_CLOSE;
				else                                            state_d = msws_pkg::S_IDLE;
			end
			msws_pkg::S_CLOSE:       state_d = msws_pkg::S_EMIT_STATUS;
			msws_pkg::S_EMIT_STATUS: if (sts.out_free) state_d = msws_pkg::S_IDLE;
			msws_pkg::S_SUM_SEL: begin
				if (sts.sel_end)         state_d = msws_pkg::S_IDLE;
				else if (!sts.fill_zero) state_d = msws_pkg::S_SUM_RD;
			end
			msws_pkg::S_SUM_RD:  state_d = msws_pkg::S_SUM_ACC;
			msws_pkg::S_SUM_ACC: begin
				if (sts.acc_last) state_d = msws_pkg::S_DIV_INIT;
				else              state_d = msws_pkg::S_SUM_RD;
			end
			msws_pkg::S_DIV_INIT: state_d = msws_pkg::S_DIV;
			msws_pkg::S_DIV:      if (sts.div_done) state_d = msws_pkg::S_EMIT_SUM;
			msws_pkg::S_EMIT_SUM: if (sts.out_free) state_d = msws_pkg::S_SUM_SEL;
			default:              state_d = msws_pkg::S_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			msws_pkg::S_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
				cmd.sum_init = in_valid;
			end
			msws_pkg::S_STEP:        cmd.do_step     = 1'b1;
			msws_pkg::S_CLOSE:       cmd.do_close    = 1'b1;
			msws_pkg::S_EMIT_STATUS: cmd.load_status = sts.out_free;
			msws_pkg::S_SUM_SEL: begin
				cmd.sum_next  = !sts.sel_end && sts.fill_zero;
				cmd.sum_begin = !sts.sel_end && !sts.fill_zero;
			end
			msws_pkg::S_SUM_ACC:  cmd.acc       = 1'b1;
			msws_pkg::S_DIV_INIT: cmd.div_begin = 1'b1;
			msws_pkg::S_DIV:      cmd.div_step  = 1'b1;
			msws_pkg::S_EMIT_SUM: begin
				cmd.load_sum = sts.out_free;
				cmd.sum_next = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hdl/msws_dpath.sv =====
// Datapath: frame bookkeeping, per-series ring heads and fills, sample memory,
// summary accumulator, serial divider and the output word register. Uses msws_pkg.
module msws_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  msws_pkg::ctl_cmd_t cmd,
	output msws_pkg::dp_sts_t  sts,
	input  logic [1:0]         in_cmd,
	input  logic [63:0]        in_frame_number,
	input  logic [15:0]        in_pass_id,
	input  logic [31:0]        in_gpu_time,
	input  logic               in_frame_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic [1:0]         frame_status,
	output logic [3:0]         series_index,
	output logic [15:0]        series_id,
	output logic [31:0]        mean_time,
	output logic [31:0]        newest_time,
	output logic [31:0]        least_time,
	output logic [31:0]        greatest_time,
	output logic [6:0]         window_fill,
	output logic               last_result
);

	localparam int PASS_W = msws_pkg::PASS_W;
	localparam int POS_W  = msws_pkg::POS_W;
	localparam int WIN_W  = msws_pkg::WIN_W;
	localparam int FILL_W = msws_pkg::FILL_W;
	localparam int ADDR_W = msws_pkg::ADDR_W;
	localparam int SUM_W  = msws_pkg::SUM_W;
	localparam int DCNT_W = msws_pkg::DCNT_W;

	// Latched input word
	msws_pkg::cmd_t cmd_q;
	logic [63:0]    fn_q;
	logic [15:0]    pid_q;
	logic [31:0]    t_q;
	logic           fend_q;

	// Frame and schedule state
	logic             open_q;
	msws_pkg::code_t  code_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] len_q;
	logic [63:0]      last_q;
	msws_pkg::fstat_t status_q;

	logic [15:0]       ids_q  [msws_pkg::MAX_PASSES];
	logic [WIN_W-1:0]  head_q [msws_pkg::MAX_PASSES];
	logic [FILL_W-1:0] fill_q [msws_pkg::MAX_PASSES];
	logic [31:0]       mem    [msws_pkg::DEPTH];
	logic [31:0]       rd_q;

	// Summary walk and divider
	logic [POS_W-1:0]  series_q;
	logic [FILL_W-1:0] k_q;
	logic [FILL_W-1:0] nfill_q;
	logic [WIN_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [31:0]       lo_q, hi_q, newest_q;
	logic              first_q;
	logic [SUM_W-1:0]  dq_q;
	logic [FILL_W-1:0] rem_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [31:0] out_mean_q, out_newest_q, out_lo_q, out_hi_q;
	logic [15:0] out_id_q;
	logic [3:0]  out_index_q;
	logic [FILL_W-1:0] out_fill_q;
	logic        out_kind_q, out_last_q, out_valid_q;
	logic [1:0]  out_status_q;

	// Step and close decode
	logic             open_now, rej_new, take, trunc_now, wr_en, chg, wr_fresh;
	logic             close_chg, close_restart, restart_en, later_live;
	msws_pkg::code_t  code_e, code_f;
	logic [POS_W-1:0] pos_e, restart_cnt;
	logic [PASS_W-1:0] sel;
	logic [WIN_W-1:0] wr_idx, head_next, head_prev;
	logic [FILL_W-1:0] fill_next;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [FILL_W:0]  trial;
	logic             qbit;
	msws_pkg::fstat_t status_d;

	always_comb begin
		open_now = !open_q;
		rej_new  = (fn_q == 64'd0) || (fn_q <= last_q);
		if (open_now) code_e = rej_new ? msws_pkg::CODE_REJECTED : msws_pkg::CODE_SAME;
		else          code_e = code_q;
		pos_e = open_now ? '0 : pos_q;
		sel   = cmd.do_step ? pos_e[PASS_W-1:0] : series_q[PASS_W-1:0];
		take  = cmd.do_step && (cmd_q == msws_pkg::CMD_ENTRY)
			&& (code_e != msws_pkg::CODE_REJECTED) && (code_e != msws_pkg::CODE_TRUNC);
		trunc_now = take && (pos_e >= POS_W'(msws_pkg::MAX_PASSES));
		wr_en     = take && !trunc_now;
		chg       = (code_e == msws_pkg::CODE_SAME) && ((pos_e >= len_q) || (ids_q[sel] != pid_q));
		wr_fresh  = chg || (code_e == msws_pkg::CODE_CHANGED);
		wr_idx    = wr_fresh ? '0 : head_q[sel];
		head_next = (wr_idx == WIN_W'(msws_pkg::WINDOW - 1)) ? '0 : wr_idx + 1'b1;
		if (wr_fresh)                                       fill_next = FILL_W'(1);
		else if (fill_q[sel] < FILL_W'(msws_pkg::WINDOW))   fill_next = fill_q[sel] + 1'b1;
		else                                                fill_next = fill_q[sel];
		wr_addr = ADDR_W'(sel) * ADDR_W'(msws_pkg::WINDOW) + ADDR_W'(wr_idx);
		rd_addr = ADDR_W'(series_q[PASS_W-1:0]) * ADDR_W'(msws_pkg::WINDOW) + ADDR_W'(idx_q);
		head_prev = (head_q[sel] == '0) ? WIN_W'(msws_pkg::WINDOW - 1) : head_q[sel] - 1'b1;

		close_chg     = cmd.do_close && (code_q != msws_pkg::CODE_REJECTED) && (pos_q != len_q);
		close_restart = close_chg && (code_q == msws_pkg::CODE_SAME);
		restart_en    = (wr_en && chg) || close_restart;
		restart_cnt   = cmd.do_close ? pos_q : pos_e;
		code_f        = close_restart ? msws_pkg::CODE_CHANGED : code_q;
		case (code_f)
			msws_pkg::CODE_REJECTED: status_d = msws_pkg::FST_REJECTED;
			msws_pkg::CODE_TRUNC:    status_d = msws_pkg::FST_TRUNC;
			msws_pkg::CODE_CHANGED:  status_d = msws_pkg::FST_CHANGED;
			default:                 status_d = msws_pkg::FST_SAME;
		endcase

		later_live = 1'b0;
		for (int j = 0; j < msws_pkg::MAX_PASSES; j++) begin
			if ((POS_W'(j) > series_q) && (POS_W'(j) < len_q) && (fill_q[j] != '0))
				later_live = 1'b1;
		end

		trial = {rem_q, dq_q[SUM_W-1]};
		qbit  = (trial >= {1'b0, nfill_q});
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q  <= msws_pkg::cmd_t'(in_cmd);
			fn_q   <= in_frame_number;
			pid_q  <= in_pass_id;
			t_q    <= in_gpu_time;
			fend_q <= in_frame_end;
		end
	end

	// Frame state: open, code, position, schedule length, last frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			code_q <= msws_pkg::CODE_SAME;
			pos_q  <= '0;
			len_q  <= '0;
			last_q <= '0;
		end else if (cmd.do_step) begin
			open_q <= 1'b1;
			if (open_now && !rej_new) last_q <= fn_q;
			if (trunc_now)  code_q <= msws_pkg::CODE_TRUNC;
			else if (wr_en) code_q <= wr_fresh ? msws_pkg::CODE_CHANGED : code_e;
			else            code_q <= code_e;
			pos_q <= wr_en ? pos_e + 1'b1 : pos_e;
		end else if (cmd.do_close) begin
			if (close_chg) len_q <= pos_q;
			open_q <= 1'b0;
			code_q <= msws_pkg::CODE_SAME;
			pos_q  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_close) status_q <= status_d;
	end

	// Ring heads and fills: restart earlier series, advance the written one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < msws_pkg::MAX_PASSES; j++) begin
				head_q[j] <= '0;
				fill_q[j] <= '0;
			end
		end else begin
			for (int j = 0; j < msws_pkg::MAX_PASSES; j++) begin
				if (restart_en && (POS_W'(j) < restart_cnt) && (fill_q[j] > FILL_W'(1)))
					fill_q[j] <= FILL_W'(1);
				if (wr_en && (PASS_W'(j) == sel)) begin
					head_q[j] <= head_next;
					fill_q[j] <= fill_next;
				end
			end
		end
	end

	// Pass ids and sample memory
	always_ff @(posedge clk) begin
		if (wr_en && wr_fresh) ids_q[sel] <= pid_q;
		if (wr_en) mem[wr_addr] <= t_q;
		rd_q <= mem[rd_addr];
	end

	// Summary walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) series_q <= '0;
		else if (cmd.sum_init) series_q <= '0;
		else if (cmd.sum_next) series_q <= series_q + 1'b1;
	end

	// Accumulate window, then divide
	always_ff @(posedge clk) begin
		if (cmd.sum_begin) begin
			k_q     <= fill_q[sel];
			nfill_q <= fill_q[sel];
			idx_q   <= head_prev;
			sum_q   <= '0;
			first_q <= 1'b1;
		end else if (cmd.acc) begin
			k_q     <= k_q - 1'b1;
			idx_q   <= (idx_q == '0) ? WIN_W'(msws_pkg::WINDOW - 1) : idx_q - 1'b1;
			sum_q   <= sum_q + SUM_W'(rd_q);
			first_q <= 1'b0;
			if (first_q) begin
				newest_q <= rd_q;
				lo_q     <= rd_q;
				hi_q     <= rd_q;
			end else begin
				if (rd_q < lo_q) lo_q <= rd_q;
				if (rd_q > hi_q) hi_q <= rd_q;
			end
		end
		if (cmd.div_begin) begin
			dq_q   <= sum_q;
			rem_q  <= '0;
			dcnt_q <= DCNT_W'(SUM_W);
		end else if (cmd.div_step) begin
			rem_q  <= qbit ? FILL_W'(trial - {1'b0, nfill_q}) : trial[FILL_W-1:0];
			dq_q   <= {dq_q[SUM_W-2:0], qbit};
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_status || cmd.load_sum) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			out_kind_q   <= msws_pkg::KIND_STATUS;
			out_status_q <= status_q;
			out_index_q  <= '0;
			out_id_q     <= '0;
			out_mean_q   <= '0;
			out_newest_q <= '0;
			out_lo_q     <= '0;
			out_hi_q     <= '0;
			out_fill_q   <= '0;
			out_last_q   <= 1'b0;
		end else if (cmd.load_sum) begin
			out_kind_q   <= msws_pkg::KIND_SUMMARY;
			out_status_q <= '0;
			out_index_q  <= 4'(series_q);
			out_id_q     <= ids_q[sel];
			out_mean_q   <= dq_q[31:0];
			out_newest_q <= newest_q;
			out_lo_q     <= lo_q;
			out_hi_q     <= hi_q;
			out_fill_q   <= nfill_q;
			out_last_q   <= !later_live;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign frame_status  = out_status_q;
	assign series_index  = out_index_q;
	assign series_id     = out_id_q;
	assign mean_time     = out_mean_q;
	assign newest_time   = out_newest_q;
	assign least_time    = out_lo_q;
	assign greatest_time = out_hi_q;
	assign window_fill   = 7'(out_fill_q);
	assign last_result   = out_last_q;

	// Status toward the controller
	always_comb begin
		sts.cmd       = cmd.latch_in ? msws_pkg::cmd_t'(in_cmd) : cmd_q;
		sts.fend      = fend_q;
		sts.sel_end   = (series_q >= len_q);
		sts.fill_zero = (fill_q[sel] == '0);
		sts.acc_last  = (k_q == FILL_W'(1));
		sts.div_done  = (dcnt_q == DCNT_W'(1));
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule

// ===== hdl/multi_series_window_statistics_core.sv =====
// Sliding-window min/max/mean over several timed passes per frame.
// Input word: cmd selects a pass timing entry, an empty frame or a summary request.
// Output word: a frame status (kind 0) or one series summary (kind 1).
// Both channels use valid/ready; a word moves when valid and ready are high together.
// One word is processed at a time; in_ready is high only while the sequencer is idle.
// Timing entry: a step state; frame_end adds a close state and a status load state.
// Empty frame: step and close, then the status word is loaded before the next input word.
// Summary: a series with no samples is skipped at select; a held series has select, a
// read and an accumulate per sample (one sample memory read port), divider start, 39 serial
// divider steps (one quotient bit each) and output load; a final select ends the walk.
// last_result marks the final series word. No words for an empty schedule.
// The output register frees the sequencer once a word is loaded; a stalled receiver
// holds the sequencer only when a further word is ready to be loaded.
// Reset (arst_n low) clears the schedule, fills, heads and last frame number; the
// sample memory and pass ids need no clearing pass and are written before being read.
// Depends on msws_pkg, msws_ctrl and msws_dpath.
module multi_series_window_statistics_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [63:0] frame_number,
	input  logic [15:0] pass_id,
	input  logic [31:0] gpu_time,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [1:0]  frame_status,
	output logic [3:0]  series_index,
	output logic [15:0] series_id,
	output logic [31:0] mean_time,
	output logic [31:0] newest_time,
	output logic [31:0] least_time,
	output logic [31:0] greatest_time,
	output logic [6:0]  window_fill,
	output logic        last_result
);

	msws_pkg::ctl_cmd_t ctl_cmd;
	msws_pkg::dp_sts_t  dp_sts;

	// Sequencer
	msws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	// Datapath
	msws_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (ctl_cmd),
		.sts             (dp_sts),
		.in_cmd          (cmd),
		.in_frame_number (frame_number),
		.in_pass_id      (pass_id),
		.in_gpu_time     (gpu_time),
		.in_frame_end    (frame_end),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.frame_status    (frame_status),
		.series_index    (series_index),
		.series_id       (series_id),
		.mean_time       (mean_time),
		.newest_time     (newest_time),
		.least_time      (least_time),
		.greatest_time   (greatest_time),
		.window_fill     (window_fill),
		.last_result     (last_result)
	);

endmodule

// ===== bench/multi_series_window_statistics_core_test.sv =====
// Self-checking bench for multi_series_window_statistics_core: random and directed frames.
// Depends on msws_pkg and the core RTL; predicts status and summary words per accepted word.
`timescale 1ns / 100ps

module multi_series_window_statistics_core_test;

	typedef struct {
		msws_pkg::cmd_t op;
		logic [63:0]    fnum;
		logic [15:0]    pid;
		logic [31:0]    tval;
		logic           fend;
		bit             drain;
	} in_word_t;

	typedef struct {
		logic        kind;
		logic [1:0]  status;
		logic [3:0]  sidx;
		logic [15:0] sid;
		logic [31:0] mean;
		logic [31:0] newest;
		logic [31:0] least;
		logic [31:0] greatest;
		logic [6:0]  fill;
		logic        last;
	} out_word_t;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready;
	logic [1:0]  cmd;
	logic [63:0] frame_number;
	logic [15:0] pass_id;
	logic [31:0] gpu_time;
	logic        frame_end;
	logic        kind, last_result;
	logic [1:0]  frame_status;
	logic [3:0]  series_index;
	logic [15:0] series_id;
	logic [31:0] mean_time, newest_time, least_time, greatest_time;
	logic [6:0]  window_fill;

	multi_series_window_statistics_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .frame_number(frame_number), .pass_id(pass_id),
		.gpu_time(gpu_time), .frame_end(frame_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .frame_status(frame_status), .series_index(series_index),
		.series_id(series_id), .mean_time(mean_time), .newest_time(newest_time),
		.least_time(least_time), .greatest_time(greatest_time),
		.window_fill(window_fill), .last_result(last_result)
	);

	in_word_t  pending_words[$];
	out_word_t expected_words[$];
	int        mismatches = 0;
	longint    cycle = 0;

	// window state mirror
	logic [31:0]      ring_mem [msws_pkg::MAX_PASSES][msws_pkg::WINDOW];
	logic [15:0]      ring_ids [msws_pkg::MAX_PASSES];
	int               ring_head [msws_pkg::MAX_PASSES];
	int               ring_fill [msws_pkg::MAX_PASSES];
	int               sched_len = 0;
	int               entry_pos = 0;
	logic [63:0]      last_frame = '0;
	bit               frame_open = 0;
	msws_pkg::code_t  frame_code = msws_pkg::CODE_SAME;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		#4000000;
		$display("multi_series_window_statistics_core verification failed");
		$finish;
	end

	// Collapse each series before position count to its newest sample.
	task automatic restart_series(input int count);
		for (int j = 0; j < count && j < msws_pkg::MAX_PASSES; j++)
			if (ring_fill[j] > 1) ring_fill[j] = 1;
	endtask

	task automatic open_frame_pred(input logic [63:0] fnum);
		frame_open = 1;
		frame_code = msws_pkg::CODE_SAME;
		entry_pos = 0;
		if (fnum == 0 || fnum <= last_frame) frame_code = msws_pkg::CODE_REJECTED;
		else last_frame = fnum;
	endtask

	task automatic close_frame_pred();
		out_word_t r;
		r = '{default: '0};
		if (frame_code != msws_pkg::CODE_REJECTED && entry_pos != sched_len) begin
			if (frame_code == msws_pkg::CODE_SAME) begin
				restart_series(entry_pos);
				frame_code = msws_pkg::CODE_CHANGED;
			end
			sched_len = entry_pos;
		end
		case (frame_code)
			msws_pkg::CODE_REJECTED: r.status = msws_pkg::FST_REJECTED;
			msws_pkg::CODE_TRUNC:    r.status = msws_pkg::FST_TRUNC;
			msws_pkg::CODE_CHANGED:  r.status = msws_pkg::FST_CHANGED;
			default:                 r.status = msws_pkg::FST_SAME;
		endcase
		r.kind = msws_pkg::KIND_STATUS;
		frame_open = 0;
		frame_code = msws_pkg::CODE_SAME;
		entry_pos = 0;
		expected_words.insert(expected_words.size(), r);
	endtask

	task automatic take_entry_pred(input logic [15:0] pid, input logic [31:0] tval);
		int p;
		p = entry_pos;
		if (frame_code == msws_pkg::CODE_REJECTED || frame_code == msws_pkg::CODE_TRUNC)
			return;
		if (p >= msws_pkg::MAX_PASSES) begin
			frame_code = msws_pkg::CODE_TRUNC;
			return;
		end
		if (frame_code == msws_pkg::CODE_SAME && (p >= sched_len || ring_ids[p] != pid)) begin
			restart_series(p);
			frame_code = msws_pkg::CODE_CHANGED;
		end
		if (frame_code == msws_pkg::CODE_CHANGED) begin
			ring_ids[p] = pid;
			ring_mem[p][0] = tval;
			ring_head[p] = 1 % msws_pkg::WINDOW;
			ring_fill[p] = 1;
		end else begin
			ring_mem[p][ring_head[p]] = tval;
			ring_head[p] = (ring_head[p] + 1) % msws_pkg::WINDOW;
			if (ring_fill[p] < msws_pkg::WINDOW) ring_fill[p]++;
		end
		entry_pos = p + 1;
	endtask

	task automatic summarize_pred();
		out_word_t   r;
		int          idx, n;
		logic [63:0] total;
		logic [31:0] v;
		n = 0;
		for (int i = 0; i < sched_len && i < msws_pkg::MAX_PASSES; i++) begin
			if (ring_fill[i] == 0) continue;
			r = '{default: '0};
			idx = (ring_head[i] + msws_pkg::WINDOW - 1) % msws_pkg::WINDOW;
			r.newest = ring_mem[i][idx];
			r.least = r.newest;
			r.greatest = r.newest;
			total = 0;
			for (int k = 0; k < ring_fill[i]; k++) begin
				v = ring_mem[i][idx];
				total += v;
				if (v < r.least) r.least = v;
				if (v > r.greatest) r.greatest = v;
				idx = (idx + msws_pkg::WINDOW - 1) % msws_pkg::WINDOW;
			end
			r.kind = msws_pkg::KIND_SUMMARY;
			r.sidx = i[3:0];
			r.sid = ring_ids[i];
			r.mean = 32'(total / ring_fill[i]);
			r.fill = 7'(ring_fill[i]);
			expected_words.insert(expected_words.size(), r);
			n++;
		end
		if (n > 0) expected_words[expected_words.size() - 1].last = 1;
	endtask

	task automatic predict_word(input in_word_t w);
		case (w.op)
			msws_pkg::CMD_ENTRY: begin
				if (!frame_open) open_frame_pred(w.fnum);
				take_entry_pred(w.pid, w.tval);
				if (w.fend) close_frame_pred();
			end
			msws_pkg::CMD_EMPTY: begin
				if (!frame_open) open_frame_pred(w.fnum);
				close_frame_pred();
			end
			msws_pkg::CMD_SUMMARY: summarize_pred();
			default: ;
		endcase
	endtask

	function automatic bit quiet_stretch();
		return cycle > 3000 && cycle < 6000;
	endfunction

	// Driver: hold each word until accepted, then advance.
	always @(posedge clk or negedge arst_n) begin
		in_word_t w;
		if (!arst_n) begin
			in_valid <= 0;
			cmd <= msws_pkg::CMD_NONE;
			frame_number <= '0;
			pass_id <= '0;
			gpu_time <= '0;
			frame_end <= 0;
		end else begin
			if (in_valid && in_ready) begin
				w.op = msws_pkg::cmd_t'(cmd);
				w.fnum = frame_number;
				w.pid = pass_id;
				w.tval = gpu_time;
				w.fend = frame_end;
				predict_word(w);
			end
			if (!in_valid || in_ready) begin
				if (pending_words.size() > 0 && pending_words[0].drain) begin
					if (expected_words.size() == 0) void'(pending_words.pop_front());
					in_valid <= 0;
				end else if (pending_words.size() == 0 ||
						(!quiet_stretch() && $urandom_range(99) < 10)) begin
					in_valid <= 0;
				end else begin
					w = pending_words.pop_front();
					in_valid <= 1;
					cmd <= w.op;
					frame_number <= w.fnum;
					pass_id <= w.pid;
					gpu_time <= w.tval;
					frame_end <= w.fend;
				end
			end
		end
	end

	// Monitor: compare each result word with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			out_ready <= 0;
			cycle <= 0;
		end else begin
			cycle <= cycle + 1;
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result word kind=%0d", kind);
				end else begin
					e = expected_words.pop_front();
					if (kind !== e.kind || frame_status !== e.status ||
							series_index !== e.sidx || series_id !== e.sid ||
							mean_time !== e.mean || newest_time !== e.newest ||
							least_time !== e.least || greatest_time !== e.greatest ||
							window_fill !== e.fill || last_result !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp k%0d st%0d i%0d id%h m%h n%h l%h g%h f%0d L%0d",
								" got k%0d st%0d i%0d id%h m%h n%h l%h g%h f%0d L%0d"},
								e.kind, e.status, e.sidx, e.sid, e.mean, e.newest,
								e.least, e.greatest, e.fill, e.last,
								kind, frame_status, series_index, series_id, mean_time,
								newest_time, least_time, greatest_time, window_fill,
								last_result);
					end
				end
			end
			// long hold-off lets the core back up and stall its input
			if (cycle >= 1000 && cycle < 1400) out_ready <= 0;
			else out_ready <= quiet_stretch() || $urandom_range(99) >= 10;
		end
	end

	task automatic add_word(input msws_pkg::cmd_t op, input logic [63:0] fnum,
			input logic [15:0] pid, input logic [31:0] tval, input logic fend);
		in_word_t w;
		w = '{op, fnum, pid, tval, fend, 1'b0};
		pending_words.insert(pending_words.size(), w);
	endtask

	task automatic add_drain();
		in_word_t w;
		w = '{msws_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b1};
		pending_words.insert(pending_words.size(), w);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Send one frame over the given schedule; later entries carry junk frame numbers.
	task automatic add_frame(input logic [63:0] fnum, input logic [15:0] ids[$]);
		for (int j = 0; j < ids.size(); j++)
			add_word(msws_pkg::CMD_ENTRY, (j == 0) ? fnum : rand64(), ids[j], $urandom,
				j == ids.size() - 1);
	endtask

	initial begin
		logic [15:0] sched[$];
		logic [15:0] ids[$];
		logic [63:0] fnum;
		int          frames, pick, len;

		// directed: empty schedule, unused command, rejection, extremes
		add_word(msws_pkg::CMD_SUMMARY, '0, '0, '0, 1'b0);
		add_word(msws_pkg::CMD_NONE, '1, '1, '1, 1'b1);
		add_word(msws_pkg::CMD_EMPTY, '0, '0, '0, 1'b0);
		add_word(msws_pkg::CMD_ENTRY, '0, 16'h1234, 32'h5, 1'b1);
		add_word(msws_pkg::CMD_ENTRY, 64'd1, 16'hFFFF, 32'h0, 1'b0);
		add_word(msws_pkg::CMD_ENTRY, '1, 16'h0000, 32'hFFFF_FFFF, 1'b1);
		add_word(msws_pkg::CMD_ENTRY, 64'd2, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		add_word(msws_pkg::CMD_ENTRY, 64'd0, 16'h0000, 32'h0, 1'b1);
		add_word(msws_pkg::CMD_SUMMARY, '1, '1, '1, 1'b1);
		// empty frame shrinks the schedule to nothing
		add_word(msws_pkg::CMD_EMPTY, 64'd3, '0, '0, 1'b0);
		add_word(msws_pkg::CMD_SUMMARY, '0, '0, '0, 1'b0);
		// overlong frame: entries past the limit drop, status truncated
		for (int j = 0; j <= msws_pkg::MAX_PASSES; j++)
			add_word(msws_pkg::CMD_ENTRY, (j == 0) ? 64'd4 : rand64(), 16'(j), $urandom,
				j == msws_pkg::MAX_PASSES);
		// stale frame number, then open frame summarized and closed by an empty frame
		add_word(msws_pkg::CMD_ENTRY, 64'd4, 16'h0, 32'h7, 1'b1);
		add_word(msws_pkg::CMD_ENTRY, 64'd5, 16'h0, 32'h9, 1'b0);
		add_word(msws_pkg::CMD_SUMMARY, '0, '0, '0, 1'b0);
		add_word(msws_pkg::CMD_EMPTY, rand64(), '0, '0, 1'b0);
		add_drain();
		add_word(msws_pkg::CMD_SUMMARY, '0, '0, '0, 1'b0);

		// random: mostly well-formed frames over a stable schedule
		fnum = 64'd10;
		sched = {16'd7};
		frames = 0;
		while (pending_words.size() < 350) begin
			frames++;
			pick = $urandom_range(99);
			if (pick < 6) begin
				len = $urandom_range(1, 4);
				sched = {};
				for (int j = 0; j < len; j++) sched.insert(sched.size(), 16'($urandom));
			end
			if (pick < 4) begin
				add_frame((pick < 2) ? fnum : 64'd0, sched);
			end else if (pick < 7) begin
				fnum += 1;
				add_word(msws_pkg::CMD_EMPTY, fnum, 16'($urandom), $urandom,
					1'($urandom_range(1)));
			end else if (pick < 9) begin
				ids = sched;
				ids[$urandom_range(ids.size() - 1)] ^= 16'h1;
				fnum += $urandom_range(1, 5);
				add_frame(fnum, ids);
			end else if (pick < 11) begin
				fnum += 1;
				add_word(msws_pkg::CMD_ENTRY, fnum, sched[0], $urandom, 1'b0);
				add_word(msws_pkg::CMD_SUMMARY, rand64(), 16'($urandom), $urandom, 1'b0);
				add_word(msws_pkg::CMD_EMPTY, rand64(), '0, '0, 1'b0);
			end else if (pick < 12) begin
				add_word(msws_pkg::CMD_NONE, rand64(), 16'($urandom), $urandom,
					1'($urandom_range(1)));
			end else begin
				fnum += $urandom_range(1, 3);
				add_frame(fnum, sched);
			end
			if (frames % 9 == 0)
				add_word(msws_pkg::CMD_SUMMARY, rand64(), 16'($urandom), $urandom, 1'b0);
			if (frames == 60) add_drain();
		end
		// top of the frame number range
		add_frame(64'hFFFF_FFFF_FFFF_FFFE, sched);
		add_frame(64'hFFFF_FFFF_FFFF_FFFF, sched);
		add_frame(64'hFFFF_FFFF_FFFF_FFFF, sched);
		add_word(msws_pkg::CMD_SUMMARY, '0, '0, '0, 1'b0);

		wait (arst_n);
		wait (pending_words.size() == 0);
		while (in_valid || expected_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("multi_series_window_statistics_core verification clean");
		else
			$display("multi_series_window_statistics_core verification failed");
		$finish;
	end

endmodule
